/* hw/rtl/dppt_pkg.sv */
// ----------------------------------------------------------------------------
// dppt_pkg: shared types and constants of the debris particle table
// Record layout, command and result beats, opcodes, result kinds and the
// signed drag helper used by the update logic.
// ----------------------------------------------------------------------------
package dppt_pkg;

    // table size and slot addressing
    localparam int SLOTS   = 64;
    localparam int SLOT_W  = 6;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // stream widths
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 72;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 3;

    // result beat field positions
    localparam int OUT_POS_LSB   = SLOT_W;
    localparam int OUT_FRAME_LSB = SLOT_W + 48;
    localparam int OUT_FRAME_MSB = OUT_FRAME_LSB + 11;

    // configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 16;
    localparam logic [CFG_AW-1:0] CFG_GRAVITY    = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_FRAME_STEP = 1'd1;

    // reset values and arithmetic constants
    localparam logic [15:0] GRAVITY_RST    = 16'd5041;
    localparam logic [9:0]  FRAME_STEP_RST = 10'd85;
    localparam logic [12:0] FRAME_WRAP     = 13'd3072;
    localparam logic [8:0]  LIFE_BASE      = 9'd140;
    localparam logic [31:0] AZ_BIAS        = 32'h0001_0000;
    localparam logic [31:0] DRAG_ROUND     = 32'd255;
    localparam logic [15:0] SPLASH_OFS     = 16'd3;

    typedef enum logic [OP_W-1:0] {
        OP_SPAWN   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_TERRAIN = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_EXPIRED = 3'd1,
        KIND_QUERY   = 3'd2,
        KIND_MOVED   = 3'd3,
        KIND_SPLASH  = 3'd4
    } t_kind;

    // one input beat, unpacked
    typedef struct packed {
        t_op                    op;
        logic [SLOT_W-1:0]      slot;
        logic [2:0][15:0]       pos;
        logic [7:0]             rand_frame;
        logic [6:0]             rand_life;
        logic [2:0][15:0]       seed;
        logic [15:0]            land;
        logic [15:0]            water;
    } t_cmd;

    // one particle record
    typedef struct packed {
        logic [8:0]             life;
        logic [11:0]            frame;
        logic [2:0][15:0]       pos;
        logic [2:0][15:0]       pend;
        logic [2:0][15:0]       vel;
        logic [2:0][31:0]       acc;
    } t_rec;

    // one result beat
    typedef struct packed {
        t_kind                  kind;
        logic [SLOT_W-1:0]      slot;
        logic [15:0]            x;
        logic [15:0]            y;
        logic [15:0]            z;
        logic [11:0]            frame;
    } t_res;

    // everything the update logic hands back for one item
    typedef struct packed {
        t_rec                   rec;
        logic                   alive;
        logic                   await_h;
        t_res                   res;
    } t_upd;

    // a - a/256 with the quotient truncated toward zero
    function automatic logic [31:0] drag(input logic [31:0] a);
        logic [31:0] biased;
        logic [31:0] quot;
        biased = a + (a[31] ? DRAG_ROUND : 32'd0);
        quot   = 32'($signed(biased) >>> 8);
        return a - quot;
    endfunction

endpackage

/* hw/rtl/dppt_record_ram.sv */
// ----------------------------------------------------------------------------
// dppt_record_ram: particle record memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dppt_record_ram
    import dppt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [SLOT_AW-1:0] i_waddr,
    input  t_rec               i_wdata,
    input  logic               i_re,
    input  logic [SLOT_AW-1:0] i_raddr,
    output t_rec               o_rdata
);

    t_rec r_mem [SLOTS];
    t_rec r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/dppt_update.sv */
// ----------------------------------------------------------------------------
// dppt_update: per-item record update
// Spawn, advance and terrain answer on one slot record, giving the new
// record, the new flags and the result beat.
// ----------------------------------------------------------------------------
module dppt_update
    import dppt_pkg::*;
(
    input  t_cmd        i_cmd,
    input  t_rec        i_rec,
    input  logic        i_alive,
    input  logic        i_await_h,
    input  logic [15:0] i_gravity,
    input  logic [9:0]  i_frame_step,
    output t_upd        o_upd
);

    logic [8:0]        life_dec;
    logic [2:0][31:0]  acc_new;
    logic [2:0][31:0]  vel_sum;
    logic [2:0][15:0]  pend_new;
    logic [2:0][15:0]  pos_mv;
    logic signed [15:0] land;
    logic signed [15:0] water;
    logic signed [15:0] oldz;
    logic signed [15:0] newz;
    logic              splash;
    logic              bounce;
    logic [12:0]       frame_sum;
    logic [11:0]       frame_new;
    t_upd              u;

    // motion step: gravity, drag, velocity and pending position
    always_comb begin
        life_dec   = i_rec.life - 9'd1;
        acc_new[0] = drag(i_rec.acc[0]);
        acc_new[1] = drag(i_rec.acc[1]);
        acc_new[2] = drag(i_rec.acc[2] - {16'd0, i_gravity});
        for (int i = 0; i < 3; i++) begin
            vel_sum[i]  = {16'd0, i_rec.vel[i]} + acc_new[i];
            pend_new[i] = i_rec.pos[i] + vel_sum[i][31:16];
        end
    end

    // terrain checks and frame advance
    always_comb begin
        land      = $signed(i_cmd.land);
        water     = $signed(i_cmd.water);
        oldz      = $signed(i_rec.pos[2]);
        newz      = $signed(i_rec.pend[2]);
        splash    = (water != 16'sd0) && (oldz >= water) && (newz <= water);
        bounce    = (oldz >= land) && (newz <= land);
        frame_sum = 13'(i_rec.frame) + 13'(i_frame_step);
        frame_new = (frame_sum >= FRAME_WRAP) ? 12'd0 : frame_sum[11:0];
        pos_mv    = i_rec.pend;
        if (bounce) begin
            pos_mv[2] = i_cmd.land;
        end
    end

    // op decode and record write-back
    always_comb begin
        u          = '0;
        u.rec      = i_rec;
        u.alive    = i_alive;
        u.await_h  = i_await_h;
        u.res.kind = KIND_NONE;
        u.res.slot = i_cmd.slot;
        if (int'(i_cmd.slot) < SLOTS) begin
            unique case (i_cmd.op)
                OP_SPAWN: begin
                    u.alive     = 1'b1;
                    u.await_h   = 1'b0;
                    u.rec.pos   = i_cmd.pos;
                    u.rec.frame = (12'(i_cmd.rand_frame) << 3)
                                + (12'(i_cmd.rand_frame) << 2);
                    u.rec.life  = 9'(i_cmd.rand_life) + LIFE_BASE;
                    u.rec.acc[0] = {{14{i_cmd.seed[0][15]}}, i_cmd.seed[0], 2'b00};
                    u.rec.acc[1] = {{14{i_cmd.seed[1][15]}}, i_cmd.seed[1], 2'b00};
                    u.rec.acc[2] = {14'd0, i_cmd.seed[2], 2'b00} + AZ_BIAS;
                    u.rec.vel   = '0;
                    u.rec.pend  = '0;
                end
                OP_ADVANCE: begin
                    if (i_alive && !i_await_h) begin
                        u.rec.life = life_dec;
                        if (life_dec == 9'd0) begin
                            u.alive    = 1'b0;
                            u.res.kind = KIND_EXPIRED;
                        end else begin
                            u.rec.acc  = acc_new;
                            for (int i = 0; i < 3; i++) begin
                                u.rec.vel[i] = vel_sum[i][15:0];
                            end
                            u.rec.pend = pend_new;
                            u.await_h  = 1'b1;
                            u.res.kind = KIND_QUERY;
                            u.res.x    = pend_new[0];
                            u.res.y    = pend_new[1];
                            u.res.z    = pend_new[2];
                        end
                    end
                end
                OP_TERRAIN: begin
                    if (i_alive && i_await_h) begin
                        u.await_h = 1'b0;
                        if (splash) begin
                            u.alive    = 1'b0;
                            u.res.kind = KIND_SPLASH;
                            u.res.x    = i_rec.pos[0];
                            u.res.y    = i_rec.pos[1];
                            u.res.z    = i_cmd.water + SPLASH_OFS;
                        end else begin
                            if (bounce) begin
                                u.rec.acc[2]  = 32'd0 - i_rec.acc[2];
                                u.rec.pend[2] = i_cmd.land;
                            end
                            u.rec.pos   = pos_mv;
                            u.rec.frame = frame_new;
                            u.res.kind  = KIND_MOVED;
                            u.res.x     = pos_mv[0];
                            u.res.y     = pos_mv[1];
                            u.res.z     = pos_mv[2];
                            u.res.frame = frame_new;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_upd = u;

endmodule

/* hw/rtl/debris_particle_physics_table_core.sv */
// ----------------------------------------------------------------------------
// debris_particle_physics_table_core: debris particle table
// Keeps per-slot debris particles and runs spawn, advance and terrain answer
// items against them, one result beat per item.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries items: tuser is the opcode, tdata the slot, spawn and
//   terrain fields. m_axis carries one result beat per item: tuser is the
//   result kind, tdata the slot, position and frame.
//   i_cfg_we / i_cfg_addr / i_cfg_wdata write gravity step (0) and frame
//   step (1); write only while no item is in flight.
//   Each accepted beat is registered in the read stage while its slot record
//   is read from memory; when the result register is free the update lands
//   there and the result shows on m_axis. Throughput is one item per cycle
//   while m_axis does not stall; a same-slot item right behind its
//   predecessor takes the freshly written record from a forwarding register
//   instead of the memory read.
//   Reset clears the alive and awaiting-heights flags of every slot and the
//   pipeline and loads both config registers with their reset values; the
//   record memory is not cleared and the block takes items right after reset.
//   When m_axis stalls the result register holds, the item behind it waits
//   in the read stage and s_axis_tready drops while that stage is full.
// ----------------------------------------------------------------------------
module debris_particle_physics_table_core
    import dppt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // slot, pos_x, pos_y, pos_z, rand_frame, rand_life, seed_ax, seed_ay,
    // seed_az, land_height, water_height, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [OP_W-1:0]       s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_slot, out_x, out_y, out_z, out_frame, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic [KIND_W-1:0]     m_axis_tuser,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [CFG_DW-1:0]     i_cfg_wdata
);

    t_cmd               cmd_in;
    t_cmd               r_cmd;
    logic               r_s1_valid;
    logic               n_s1_valid;
    logic               r_out_valid;
    logic               n_out_valid;
    t_res               r_res;
    logic               r_byp;
    t_rec               r_fwd;
    t_rec               ram_rdata;
    t_rec               cur_rec;
    logic [SLOTS-1:0]   r_alive;
    logic [SLOTS-1:0]   r_await_h;
    logic [15:0]        r_gravity;
    logic [9:0]         r_frame_step;
    logic               accept;
    logic               out_free;
    logic               s1_go;
    logic               in_range;
    logic [SLOT_AW-1:0] s1_idx;
    logic [SLOT_AW-1:0] in_idx;
    t_upd               upd;

    // input beat unpack
    always_comb begin
        cmd_in.op         = t_op'(s_axis_tuser);
        cmd_in.slot       = s_axis_tdata[5:0];
        cmd_in.pos[0]     = s_axis_tdata[21:6];
        cmd_in.pos[1]     = s_axis_tdata[37:22];
        cmd_in.pos[2]     = s_axis_tdata[53:38];
        cmd_in.rand_frame = s_axis_tdata[61:54];
        cmd_in.rand_life  = s_axis_tdata[68:62];
        cmd_in.seed[0]    = s_axis_tdata[84:69];
        cmd_in.seed[1]    = s_axis_tdata[100:85];
        cmd_in.seed[2]    = s_axis_tdata[116:101];
        cmd_in.land       = s_axis_tdata[132:117];
        cmd_in.water      = s_axis_tdata[148:133];
    end

    // handshake and stage control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_go         = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_idx        = SLOT_AW'(r_cmd.slot);
    assign in_idx        = SLOT_AW'(cmd_in.slot);
    assign in_range      = int'(r_cmd.slot) < SLOTS;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
        if (s1_go) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_byp <= s1_go && (in_idx == s1_idx);
            end
        end
    end

    // read stage payload and same-slot forwarding record
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cmd_in;
            r_fwd <= upd.rec;
        end
    end

    // slot record memory
    dppt_record_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go && in_range),
        .i_waddr (s1_idx),
        .i_wdata (upd.rec),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    assign cur_rec = r_byp ? r_fwd : ram_rdata;

    // record update
    dppt_update u_update (
        .i_cmd        (r_cmd),
        .i_rec        (cur_rec),
        .i_alive      (r_alive[s1_idx]),
        .i_await_h    (r_await_h[s1_idx]),
        .i_gravity    (r_gravity),
        .i_frame_step (r_frame_step),
        .o_upd        (upd)
    );

    // per-slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive   <= '0;
            r_await_h <= '0;
        end else if (s1_go && in_range) begin
            r_alive[s1_idx]   <= upd.alive;
            r_await_h[s1_idx] <= upd.await_h;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_res <= upd.res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tdata  = {6'd0, r_res.frame, r_res.z, r_res.y, r_res.x, r_res.slot};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity    <= GRAVITY_RST;
            r_frame_step <= FRAME_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GRAVITY:    r_gravity    <= i_cfg_wdata;
                CFG_FRAME_STEP: r_frame_step <= i_cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/dppt_checker.sv */
// ----------------------------------------------------------------------------
// dppt_checker: port-level checks of the debris particle table
// Watches the result stream for hold, reset and field zeroing rules.
// ----------------------------------------------------------------------------
module dppt_checker
    import dppt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]     m_axis_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // empty and expired results carry no position or frame
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (t_kind'(m_axis_tuser) == KIND_NONE ||
                          t_kind'(m_axis_tuser) == KIND_EXPIRED) |->
            m_axis_tdata[OUT_FRAME_MSB:OUT_POS_LSB] == '0)
        else $error("nonzero fields on empty or expired result");

    // query and splash results carry no frame
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (t_kind'(m_axis_tuser) == KIND_QUERY ||
                          t_kind'(m_axis_tuser) == KIND_SPLASH) |->
            m_axis_tdata[OUT_FRAME_MSB:OUT_FRAME_LSB] == '0)
        else $error("nonzero frame on query or splash result");

endmodule

bind debris_particle_physics_table_core dppt_checker u_dppt_checker (.*);
